@@ rtl/core/dwp_pkg.sv @@
// Shared types and constants for the depth/world projection pipeline.
// No dependencies; used by every module under rtl/core.
package dwp_pkg;

    localparam int QW = 35;
    localparam int DIV_STAGES = QW;

    localparam logic CMD_D2W = 1'b0;
    localparam logic CMD_W2D = 1'b1;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_DIVZ = 2'd1;
    localparam logic [1:0] ST_SAT  = 2'd2;

    localparam logic [2:0] CFG_RES_X  = 3'd0;
    localparam logic [2:0] CFG_RES_Y  = 3'd1;
    localparam logic [2:0] CFG_XZ     = 3'd2;
    localparam logic [2:0] CFG_YZ     = 3'd3;
    localparam logic [2:0] CFG_COEF_X = 3'd4;
    localparam logic [2:0] CFG_COEF_Y = 3'd5;
    localparam logic [2:0] CFG_HALF_X = 3'd6;
    localparam logic [2:0] CFG_HALF_Y = 3'd7;

    localparam logic [11:0] RST_RES_X  = 12'd640;
    localparam logic [11:0] RST_RES_Y  = 12'd480;
    localparam logic [31:0] RST_ONE    = 32'd65536;
    localparam logic [31:0] RST_HALF_X = 32'd20971520;
    localparam logic [31:0] RST_HALF_Y = 32'd15728640;

    localparam logic signed [QW+1:0] Q_BIG = 37'sh8_0000_0000;
    localparam logic signed [31:0] S32_MAX = 32'sh7fff_ffff;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic [11:0] res_x;
        logic [11:0] res_y;
        logic [31:0] xz;
        logic [31:0] yz;
        logic [31:0] coef_x;
        logic [31:0] coef_y;
        logic [31:0] half_x;
        logic [31:0] half_y;
    } t_cfg;

    typedef struct packed {
        logic [31:0]   rem;
        logic [QW-1:0] quo;
        logic [31:0]   dvs;
        logic          neg;
        logic          ovf;
    } t_lane;

    typedef struct packed {
        logic        cmd;
        logic [31:0] z;
    } t_side;

    typedef struct packed {
        t_side side;
        t_lane lx;
        t_lane ly;
    } t_div;

endpackage

@@ rtl/core/dwp_prep.sv @@
// Front stages: input register, operand products and numerators, divider setup.
// Depends on dwp_pkg.
module dwp_prep (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  dwp_pkg::t_cfg       i_cfg,
    input  logic                i_valid,
    input  logic                i_cmd,
    input  logic signed [31:0]  i_x,
    input  logic signed [31:0]  i_y,
    input  logic signed [31:0]  i_z,
    output logic                o_valid,
    output dwp_pkg::t_div       o_div
);

    logic               r1_vld;
    logic               r1_cmd;
    logic signed [31:0] r1_x, r1_y, r1_z;

    logic               r2_vld;
    logic               r2_cmd;
    logic signed [31:0] r2_z;
    logic signed [63:0] r2_ax, r2_ay;
    logic signed [34:0] r2_nx, r2_ny;
    logic [12:0]        r2_dx, r2_dy;

    logic               r3_vld;
    dwp_pkg::t_div      r3_div;

    logic signed [63:0] n2_ax, n2_ay;
    logic signed [34:0] n2_nx, n2_ny;
    logic [11:0]        rx, ry;
    dwp_pkg::t_div      n3_div;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
        end else if (i_en) begin
            r1_vld <= i_valid;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
        end
    end

    always_comb begin
        rx = (i_cfg.res_x == 12'd0) ? 12'd1 : i_cfg.res_x;
        ry = (i_cfg.res_y == 12'd0) ? 12'd1 : i_cfg.res_y;
        n2_ax = 64'($signed({1'b0, i_cfg.coef_x})) * 64'(r1_x);
        n2_ay = 64'($signed({1'b0, i_cfg.coef_y})) * 64'(r1_y);
        n2_nx = $signed({{2{r1_x[31]}}, r1_x, 1'b0}) - $signed({7'd0, rx, 16'd0});
        n2_ny = $signed({7'd0, ry, 16'd0}) - $signed({{2{r1_y[31]}}, r1_y, 1'b0});
    end

    function automatic dwp_pkg::t_lane setup(input logic cmd, input logic signed [63:0] a,
                                             input logic signed [34:0] num,
                                             input logic [12:0] dres,
                                             input logic signed [31:0] z);
        dwp_pkg::t_lane l;
        logic [63:0]    mag;
        logic [31:0]    zmag;
        logic           zz;
        zz   = (z == 32'sd0);
        zmag = z[31] ? (~z + 32'd1) : z;
        if (cmd == dwp_pkg::CMD_W2D) begin
            mag   = a[63] ? (~a + 64'd1) : a;
            l.dvs = zz ? 32'd1 : zmag;
            l.neg = a[63] ^ z[31];
            l.ovf = zz ? (a != 64'sd0) : ({3'd0, mag[63:35]} >= l.dvs);
        end else begin
            mag   = {29'd0, (num[34] ? (~num + 35'd1) : num)};
            l.dvs = {19'd0, dres};
            l.neg = num[34];
            l.ovf = 1'b0;
        end
        l.rem = {3'd0, mag[63:35]};
        l.quo = mag[34:0];
        return l;
    endfunction

    always_comb begin
        n3_div.side.cmd = r2_cmd;
        n3_div.side.z   = r2_z;
        n3_div.lx = setup(r2_cmd, r2_ax, r2_nx, r2_dx, r2_z);
        n3_div.ly = setup(r2_cmd, r2_ay, r2_ny, r2_dy, r2_z);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_cmd <= i_cmd;
            r1_x   <= i_x;
            r1_y   <= i_y;
            r1_z   <= i_z;
            r2_cmd <= r1_cmd;
            r2_z   <= r1_z;
            r2_ax  <= n2_ax;
            r2_ay  <= n2_ay;
            r2_nx  <= n2_nx;
            r2_ny  <= n2_ny;
            r2_dx  <= {rx, 1'b0};
            r2_dy  <= {ry, 1'b0};
            r3_div <= n3_div;
        end
    end

    assign o_valid = r3_vld;
    assign o_div   = r3_div;

endmodule

@@ rtl/core/dwp_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, two lanes.
// Depends on dwp_pkg.
module dwp_div (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  dwp_pkg::t_div  i_div,
    output logic           o_valid,
    output dwp_pkg::t_div  o_div
);

    localparam int NST = dwp_pkg::DIV_STAGES;

    logic          r_vld [NST];
    dwp_pkg::t_div r_stg [NST];

    function automatic dwp_pkg::t_lane step(input dwp_pkg::t_lane l);
        dwp_pkg::t_lane o;
        logic [32:0]    r2;
        logic [32:0]    diff;
        r2   = {l.rem, l.quo[dwp_pkg::QW-1]};
        diff = r2 - {1'b0, l.dvs};
        o    = l;
        if (!diff[32]) begin
            o.rem = diff[31:0];
            o.quo = {l.quo[dwp_pkg::QW-2:0], 1'b1};
        end else begin
            o.rem = r2[31:0];
            o.quo = {l.quo[dwp_pkg::QW-2:0], 1'b0};
        end
        return o;
    endfunction

    for (genvar k = 0; k < NST; k++) begin : g_stage
        dwp_pkg::t_div src;
        logic          src_vld;
        if (k == 0) begin : g_first
            assign src     = i_div;
            assign src_vld = i_valid;
        end else begin : g_next
            assign src     = r_stg[k-1];
            assign src_vld = r_vld[k-1];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= src_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_stg[k].side <= src.side;
                r_stg[k].lx   <= step(src.lx);
                r_stg[k].ly   <= step(src.ly);
            end
        end
    end

    assign o_valid = r_vld[NST-1];
    assign o_div   = r_stg[NST-1];

`ifndef SYNTHESIS
    a_rem_x: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[NST-1] && !r_stg[NST-1].lx.ovf |-> r_stg[NST-1].lx.rem < r_stg[NST-1].lx.dvs)
        else $error("x lane remainder not below divisor");
    a_rem_y: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[NST-1] && !r_stg[NST-1].ly.ovf |-> r_stg[NST-1].ly.rem < r_stg[NST-1].ly.dvs)
        else $error("y lane remainder not below divisor");
`endif

endmodule

@@ rtl/core/dwp_post.sv @@
// Back stages: quotient sign fixup, depth scaling products, offsets and saturation.
// Depends on dwp_pkg; holds the output register.
module dwp_post (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  dwp_pkg::t_cfg       i_cfg,
    input  logic                i_valid,
    input  dwp_pkg::t_div       i_div,
    output logic                o_valid,
    output logic signed [31:0]  o_x,
    output logic signed [31:0]  o_y,
    output logic signed [31:0]  o_z,
    output logic [1:0]          o_status
);

    logic               r1_vld, r2_vld, r3_vld, r4_vld, r5_vld;
    logic               r1_cmd, r2_cmd, r3_cmd, r4_cmd;
    logic               r1_dz, r2_dz, r3_dz, r4_dz;
    logic signed [31:0] r1_z, r2_z, r3_z, r4_z;
    logic signed [36:0] r1_qx, r1_qy, r2_qx, r2_qy, r3_qx, r3_qy, r4_qx, r4_qy;
    logic signed [53:0] r2_hx, r2_lx, r2_hy, r2_ly;
    logic signed [53:0] r3_px, r3_py;
    logic signed [70:0] r4_hx, r4_lx, r4_hy, r4_ly;
    logic signed [31:0] r5_x, r5_y, r5_z;
    logic [1:0]         r5_status;

    logic signed [36:0] n1_qx, n1_qy;
    logic signed [15:0] zhi;
    logic signed [16:0] zlo, fhx, flx, fhy, fly;
    logic signed [69:0] s3x, s3y;
    logic signed [86:0] s5x, s5y;
    logic signed [70:0] tx, ty;
    logic signed [37:0] wx, wy;
    logic signed [31:0] n5_x, n5_y;
    logic               satx, saty;
    logic [1:0]         n5_status;

    function automatic logic signed [36:0] fix(input dwp_pkg::t_lane l);
        logic signed [36:0] q0;
        q0 = $signed({2'd0, l.quo});
        if (l.ovf) begin
            return l.neg ? -dwp_pkg::Q_BIG : dwp_pkg::Q_BIG;
        end
        return l.neg ? (-q0 - 37'(l.rem != 32'd0)) : q0;
    endfunction

    always_comb begin
        n1_qx = fix(i_div.lx);
        n1_qy = fix(i_div.ly);
        zhi   = r1_z[31:16];
        zlo   = $signed({1'b0, r1_z[15:0]});
        fhx   = $signed({1'b0, i_cfg.xz[31:16]});
        flx   = $signed({1'b0, i_cfg.xz[15:0]});
        fhy   = $signed({1'b0, i_cfg.yz[31:16]});
        fly   = $signed({1'b0, i_cfg.yz[15:0]});
        s3x   = $signed({r2_hx, 16'd0}) + 70'(r2_lx);
        s3y   = $signed({r2_hy, 16'd0}) + 70'(r2_ly);
        s5x   = $signed({r4_hx, 16'd0}) + 87'(r4_lx);
        s5y   = $signed({r4_hy, 16'd0}) + 87'(r4_ly);
        tx    = s5x[86:16];
        ty    = s5y[86:16];
        wx    = 38'(r4_qx) + $signed({6'd0, i_cfg.half_x});
        wy    = $signed({6'd0, i_cfg.half_y}) - 38'(r4_qy);
        if (r4_cmd == dwp_pkg::CMD_W2D) begin
            satx = (wx[37:31] != {7{wx[37]}});
            saty = (wy[37:31] != {7{wy[37]}});
            n5_x = satx ? (wx[37] ? dwp_pkg::S32_MIN : dwp_pkg::S32_MAX) : wx[31:0];
            n5_y = saty ? (wy[37] ? dwp_pkg::S32_MIN : dwp_pkg::S32_MAX) : wy[31:0];
        end else begin
            satx = (tx[70:31] != {40{tx[70]}});
            saty = (ty[70:31] != {40{ty[70]}});
            n5_x = satx ? (tx[70] ? dwp_pkg::S32_MIN : dwp_pkg::S32_MAX) : tx[31:0];
            n5_y = saty ? (ty[70] ? dwp_pkg::S32_MIN : dwp_pkg::S32_MAX) : ty[31:0];
        end
        if (r4_dz) begin
            n5_status = dwp_pkg::ST_DIVZ;
        end else if (satx || saty) begin
            n5_status = dwp_pkg::ST_SAT;
        end else begin
            n5_status = dwp_pkg::ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
            r5_vld <= 1'b0;
        end else if (i_en) begin
            r1_vld <= i_valid;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            r4_vld <= r3_vld;
            r5_vld <= r4_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_cmd <= i_div.side.cmd;
            r1_z   <= i_div.side.z;
            r1_dz  <= (i_div.side.cmd == dwp_pkg::CMD_W2D) && (i_div.side.z == 32'd0);
            r1_qx  <= n1_qx;
            r1_qy  <= n1_qy;

            r2_cmd <= r1_cmd;
            r2_z   <= r1_z;
            r2_dz  <= r1_dz;
            r2_qx  <= r1_qx;
            r2_qy  <= r1_qy;
            r2_hx  <= 54'(r1_qx) * 54'(zhi);
            r2_lx  <= 54'(r1_qx) * 54'(zlo);
            r2_hy  <= 54'(r1_qy) * 54'(zhi);
            r2_ly  <= 54'(r1_qy) * 54'(zlo);

            r3_cmd <= r2_cmd;
            r3_z   <= r2_z;
            r3_dz  <= r2_dz;
            r3_qx  <= r2_qx;
            r3_qy  <= r2_qy;
            r3_px  <= s3x[69:16];
            r3_py  <= s3y[69:16];

            r4_cmd <= r3_cmd;
            r4_z   <= r3_z;
            r4_dz  <= r3_dz;
            r4_qx  <= r3_qx;
            r4_qy  <= r3_qy;
            r4_hx  <= 71'(r3_px) * 71'(fhx);
            r4_lx  <= 71'(r3_px) * 71'(flx);
            r4_hy  <= 71'(r3_py) * 71'(fhy);
            r4_ly  <= 71'(r3_py) * 71'(fly);

            r5_x      <= n5_x;
            r5_y      <= n5_y;
            r5_z      <= r4_z;
            r5_status <= n5_status;
        end
    end

    assign o_valid  = r5_vld;
    assign o_x      = r5_x;
    assign o_y      = r5_y;
    assign o_z      = r5_z;
    assign o_status = r5_status;

`ifndef SYNTHESIS
    a_sat_ext: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r5_vld && r5_status == dwp_pkg::ST_SAT |->
            r5_x == dwp_pkg::S32_MAX || r5_x == dwp_pkg::S32_MIN ||
            r5_y == dwp_pkg::S32_MAX || r5_y == dwp_pkg::S32_MIN)
        else $error("saturation status without an extreme coordinate");
    a_divz_z: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r5_vld && r5_status == dwp_pkg::ST_DIVZ |-> r5_z == 32'sd0)
        else $error("divide status with nonzero Z");
`endif

endmodule

@@ rtl/core/depth_world_projection.sv @@
// Pinhole projection between depth-image and world coordinates, Q16.16.
// Accepts one request per cycle unless a valid output is stalled, which raises o_in_stall.
// The 35-stage quotient pipeline sets the depth; a stalled output freezes all stages.
// Synchronous active-low reset clears all valid bits and loads the config defaults.
// Depends on dwp_pkg, dwp_prep, dwp_div, dwp_post.
module depth_world_projection (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic                i_cmd,
    input  logic signed [31:0]  i_in_x,
    input  logic signed [31:0]  i_in_y,
    input  logic signed [31:0]  i_in_z,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic signed [31:0]  o_out_x,
    output logic signed [31:0]  o_out_y,
    output logic signed [31:0]  o_out_z,
    output logic [1:0]          o_status,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [2:0]          i_cfg_index,
    input  logic [31:0]         i_cfg_data
);

    dwp_pkg::t_cfg r_cfg;
    logic          en;
    logic          prep_vld, div_vld;
    dwp_pkg::t_div prep_div, div_out;

    assign en          = !(o_out_valid && i_out_stall);
    assign o_in_stall  = !en;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.res_x  <= dwp_pkg::RST_RES_X;
            r_cfg.res_y  <= dwp_pkg::RST_RES_Y;
            r_cfg.xz     <= dwp_pkg::RST_ONE;
            r_cfg.yz     <= dwp_pkg::RST_ONE;
            r_cfg.coef_x <= dwp_pkg::RST_ONE;
            r_cfg.coef_y <= dwp_pkg::RST_ONE;
            r_cfg.half_x <= dwp_pkg::RST_HALF_X;
            r_cfg.half_y <= dwp_pkg::RST_HALF_Y;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                dwp_pkg::CFG_RES_X:  r_cfg.res_x  <= i_cfg_data[11:0];
                dwp_pkg::CFG_RES_Y:  r_cfg.res_y  <= i_cfg_data[11:0];
                dwp_pkg::CFG_XZ:     r_cfg.xz     <= i_cfg_data;
                dwp_pkg::CFG_YZ:     r_cfg.yz     <= i_cfg_data;
                dwp_pkg::CFG_COEF_X: r_cfg.coef_x <= i_cfg_data;
                dwp_pkg::CFG_COEF_Y: r_cfg.coef_y <= i_cfg_data;
                dwp_pkg::CFG_HALF_X: r_cfg.half_x <= i_cfg_data;
                dwp_pkg::CFG_HALF_Y: r_cfg.half_y <= i_cfg_data;
                default: ;
            endcase
        end
    end

    dwp_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_cfg   (r_cfg),
        .i_valid (i_in_valid),
        .i_cmd   (i_cmd),
        .i_x     (i_in_x),
        .i_y     (i_in_y),
        .i_z     (i_in_z),
        .o_valid (prep_vld),
        .o_div   (prep_div)
    );

    dwp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (prep_vld),
        .i_div   (prep_div),
        .o_valid (div_vld),
        .o_div   (div_out)
    );

    dwp_post u_post (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_cfg    (r_cfg),
        .i_valid  (div_vld),
        .i_div    (div_out),
        .o_valid  (o_out_valid),
        .o_x      (o_out_x),
        .o_y      (o_out_y),
        .o_z      (o_out_z),
        .o_status (o_status)
    );

endmodule
